### rtl/sorted_priority_table_unit_assert.svh
// Assertion macros for the sorted priority table unit.
`ifndef SORTED_PRIORITY_TABLE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_TABLE_UNIT_ASSERT_SVH

// The expression must never hold outside reset.
`define SPT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// When the condition holds, the consequence holds in the next cycle.
`define SPT_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

### rtl/spt_pkg.sv
// Types and codes shared by the sorted priority table unit.
package spt_pkg;

  // Operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_EDIT   = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_STATS  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_BADSEV   = 3'd5;

  localparam logic [2:0] SEV_MIN = 3'd1;
  localparam logic [2:0] SEV_MAX = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ticket;
    logic [7:0]  age_in;
    logic [2:0]  severity_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  position;
    logic [15:0] ticket_out;
    logic [7:0]  age_out;
    logic [2:0]  severity_out;
    logic [8:0]  entry_count;
    logic [8:0]  level1_count;
    logic [8:0]  level2_count;
    logic [8:0]  level3_count;
    logic [8:0]  level4_count;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic [15:0] ticket;
    logic [7:0]  age;
    logic [2:0]  severity;
  } entry_t;

endpackage

### rtl/spt_mem.sv
// Entry table storage: one write port, one registered read port.
module spt_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spt_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output spt_pkg::entry_t rdata
);

  spt_pkg::entry_t mem [DEPTH];
  spt_pkg::entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/sorted_priority_table_unit.sv
// Sorted priority table: entries held in a memory in (severity, ticket) order.
// Channels: in_valid/in_ready/in_data carries one operation item (insert,
// lookup, edit, remove, stats); out_valid/out_ready/out_data carries the one
// result item each operation produces. No configuration port.
// One item is worked at a time. Each table operation that is not refused as
// full or empty first streams the held entries through the memory read port,
// one entry a cycle, finding the ticket, the sorted slot and the per-severity
// counts together. A successful insert, edit or remove then moves entries one
// place as needed, each entry read and then written back; insert and edit end
// with a write of the new entry. Full, empty and unknown operations skip the
// scan and go straight to the result.
// Reset empties the table at once; memory contents are never cleared, since
// only entries below the held count are read.
// A finished result waits in the output register while out_ready is low; the
// next item is still taken and worked, and waits only for its own result slot.
module sorted_priority_table_unit #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spt_pkg::out_item_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SH_RD, S_SH_WR, S_WRITE, S_DONE
  } state_t;

  state_t             state_r;
  spt_pkg::in_item_t  req_r;
  spt_pkg::out_item_t res_r;
  spt_pkg::out_item_t out_data_r;
  spt_pkg::out_item_t out_data_nxt;
  logic               out_valid_r;
  logic [CNT_W-1:0]   held_r;

  // scan state
  logic [CNT_W-1:0]   rd_idx_r;
  logic               p_vld_r;
  logic [IDX_W-1:0]   p_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   idx_r;
  spt_pkg::entry_t    hit_r;
  logic [CNT_W-1:0]   pos_r;
  logic [CNT_W-1:0]   lvl1_r, lvl2_r, lvl3_r, lvl4_r;

  // shift state
  logic [IDX_W-1:0]   sh_a_r;
  logic [IDX_W-1:0]   sh_end_r;
  logic               sh_up_r;
  logic               sh_then_wr_r;

  // memory port
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;
  spt_pkg::entry_t    mem_wdata;
  spt_pkg::entry_t    mem_rdata;

  logic               in_fire;
  logic               out_fire;
  logic               done_fire;
  logic               issue;
  logic               sev_ok;
  logic               key_less;
  logic [IDX_W-1:0]   pos_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign issue   = (rd_idx_r < held_r);
  assign sev_ok  = (req_r.severity_in >= spt_pkg::SEV_MIN) &&
                   (req_r.severity_in <= spt_pkg::SEV_MAX);
  assign key_less = ({mem_rdata.severity, mem_rdata.ticket} <
                     {req_r.severity_in, req_r.ticket});
  assign pos_idx = pos_r[IDX_W-1:0];

  // result with the final entry count
  always_comb begin
    out_data_nxt             = res_r;
    out_data_nxt.entry_count = 9'(held_r);
  end

  spt_mem #(.DEPTH(CAPACITY), .AW(IDX_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sh_up_r ? (sh_a_r + 1'b1) : (sh_a_r - 1'b1);
    mem_wdata = mem_rdata;
    mem_raddr = (state_r == S_SCAN) ? rd_idx_r[IDX_W-1:0] : sh_a_r;
    if (state_r == S_SH_WR) begin
      mem_we = 1'b1;
    end else if (state_r == S_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = pos_idx;
      mem_wdata = '{ticket: req_r.ticket, age: req_r.age_in,
                    severity: req_r.severity_in};
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      p_vld_r     <= 1'b0;
    end else begin
      out_valid_r <= done_fire || (out_valid_r && !out_fire);
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r    <= in_data;
            rd_idx_r <= '0;
            p_vld_r  <= 1'b0;
            found_r  <= 1'b0;
            pos_r    <= '0;
            lvl1_r   <= '0;
            lvl2_r   <= '0;
            lvl3_r   <= '0;
            lvl4_r   <= '0;
            if (in_data.op == spt_pkg::OP_INSERT) begin
              if (held_r >= CAP_CNT) begin
                res_r   <= '{status: spt_pkg::ST_FULL, default: '0};
                state_r <= S_DONE;
              end else begin
                res_r   <= '0;
                state_r <= S_SCAN;
              end
            end else if (in_data.op == spt_pkg::OP_LOOKUP ||
                         in_data.op == spt_pkg::OP_EDIT ||
                         in_data.op == spt_pkg::OP_REMOVE ||
                         in_data.op == spt_pkg::OP_STATS) begin
              if (held_r == '0) begin
                res_r   <= '{status: spt_pkg::ST_EMPTY, default: '0};
                state_r <= S_DONE;
              end else begin
                res_r   <= '0;
                state_r <= S_SCAN;
              end
            end else begin
              res_r   <= '0;
              state_r <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          // stream entries; data returns in the cycle after the address
          if (issue) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
          p_vld_r <= issue;
          p_idx_r <= rd_idx_r[IDX_W-1:0];
          if (p_vld_r) begin
            if (mem_rdata.ticket == req_r.ticket) begin
              if (!found_r) begin
                found_r <= 1'b1;
                idx_r   <= p_idx_r;
                hit_r   <= mem_rdata;
              end
            end else if (key_less) begin
              pos_r <= pos_r + 1'b1;
            end
            case (mem_rdata.severity)
              3'd1: lvl1_r <= lvl1_r + 1'b1;
              3'd2: lvl2_r <= lvl2_r + 1'b1;
              3'd3: lvl3_r <= lvl3_r + 1'b1;
              3'd4: lvl4_r <= lvl4_r + 1'b1;
              default: ;
            endcase
          end
          if (!issue && !p_vld_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_r <= S_DONE;
          unique case (req_r.op)
            spt_pkg::OP_INSERT: begin
              if (found_r) begin
                res_r.status <= spt_pkg::ST_DUP;
              end else if (!sev_ok) begin
                res_r.status <= spt_pkg::ST_BADSEV;
              end else begin
                res_r.position <= 8'(pos_r);
                held_r         <= held_r + 1'b1;
                sh_then_wr_r   <= 1'b1;
                if (pos_r < held_r) begin
                  sh_up_r  <= 1'b1;
                  sh_a_r   <= IDX_W'(held_r - 1'b1);
                  sh_end_r <= pos_idx;
                  state_r  <= S_SH_RD;
                end else begin
                  state_r <= S_WRITE;
                end
              end
            end
            spt_pkg::OP_LOOKUP: begin
              if (!found_r) begin
                res_r.status <= spt_pkg::ST_NOTFOUND;
              end else begin
                res_r.position     <= 8'(idx_r);
                res_r.ticket_out   <= hit_r.ticket;
                res_r.age_out      <= hit_r.age;
                res_r.severity_out <= hit_r.severity;
              end
            end
            spt_pkg::OP_EDIT: begin
              if (!found_r) begin
                res_r.status <= spt_pkg::ST_NOTFOUND;
              end else if (!sev_ok) begin
                res_r.status <= spt_pkg::ST_BADSEV;
              end else begin
                res_r.position <= 8'(pos_r);
                sh_then_wr_r   <= 1'b1;
                if (pos_idx < idx_r) begin
                  sh_up_r  <= 1'b1;
                  sh_a_r   <= idx_r - 1'b1;
                  sh_end_r <= pos_idx;
                  state_r  <= S_SH_RD;
                end else if (pos_idx > idx_r) begin
                  sh_up_r  <= 1'b0;
                  sh_a_r   <= idx_r + 1'b1;
                  sh_end_r <= pos_idx;
                  state_r  <= S_SH_RD;
                end else begin
                  state_r <= S_WRITE;
                end
              end
            end
            spt_pkg::OP_REMOVE: begin
              if (!found_r) begin
                res_r.status <= spt_pkg::ST_NOTFOUND;
              end else begin
                res_r.position <= 8'(idx_r);
                held_r         <= held_r - 1'b1;
                sh_then_wr_r   <= 1'b0;
                if (CNT_W'(idx_r) + 1'b1 < held_r) begin
                  sh_up_r  <= 1'b0;
                  sh_a_r   <= idx_r + 1'b1;
                  sh_end_r <= IDX_W'(held_r - 1'b1);
                  state_r  <= S_SH_RD;
                end
              end
            end
            spt_pkg::OP_STATS: begin
              res_r.level1_count <= 9'(lvl1_r);
              res_r.level2_count <= 9'(lvl2_r);
              res_r.level3_count <= 9'(lvl3_r);
              res_r.level4_count <= 9'(lvl4_r);
            end
            default: ;
          endcase
        end
        S_SH_RD: begin
          state_r <= S_SH_WR;
        end
        S_SH_WR: begin
          // entry moved one place this cycle
          if (sh_a_r == sh_end_r) begin
            state_r <= sh_then_wr_r ? S_WRITE : S_DONE;
          end else begin
            sh_a_r  <= sh_up_r ? (sh_a_r - 1'b1) : (sh_a_r + 1'b1);
            state_r <= S_SH_RD;
          end
        end
        S_WRITE: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            out_data_r <= out_data_nxt;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "sorted_priority_table_unit_assert.svh"

  `SPT_ASSERT_NEVER(a_held_bound, held_r > CAP_CNT, "held count above capacity")
  `SPT_ASSERT_NEVER(a_no_idle_write, mem_we && state_r == S_IDLE, "table write while idle")
  `SPT_ASSERT_NEXT(a_accept_busy, in_fire, state_r != S_IDLE, "item accepted but not worked")

endmodule
